@@ rtl/tsrs_pkg.sv @@
// Shared types, codes and reset constants of the time sync retry supervisor.
// Used by every module of the block; no dependencies of its own.
package tsrs_pkg;

    // Widths of the time base and of the stream payloads.
    localparam int unsigned TimeW      = 32;
    localparam int unsigned InDataW    = 40;
    localparam int unsigned OutDataW   = 8;
    localparam int unsigned CfgIdxW    = 2;

    // Register reset values in milliseconds.
    localparam logic [TimeW-1:0] FirstDelayRst   = 32'd60000;
    localparam logic [TimeW-1:0] ResyncRst       = 32'd18000000;
    localparam logic [TimeW-1:0] AttemptTmoRst   = 32'd300000;
    localparam logic [TimeW-1:0] FallbackTestRst = 32'd180000;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_FIRST_DELAY  = 2'd0,
        CFG_RESYNC       = 2'd1,
        CFG_ATTEMPT_TMO  = 2'd2,
        CFG_FALLBACK_TST = 2'd3
    } t_cfg_idx;

    // Item kinds carried on tuser.
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_POLL  = 1'b1
    } t_cmd;

    // System state reported with each poll.
    typedef enum logic [1:0] {
        SYS_OTHER    = 2'd0,
        SYS_FALLBACK = 2'd1,
        SYS_ERROR    = 2'd2
    } t_sys_state;

    // System state write requests.
    typedef enum logic [1:0] {
        SW_NONE     = 2'd0,
        SW_RUN      = 2'd1,
        SW_FALLBACK = 2'd2,
        SW_ERROR    = 2'd3
    } t_state_write;

    // Log codes.
    typedef enum logic [1:0] {
        LOG_NONE        = 2'd0,
        LOG_TEST_START  = 2'd1,
        LOG_RETRY_LATER = 2'd2,
        LOG_GAVE_UP     = 2'd3
    } t_log_code;

    // Operand choice for the single next-due adder.
    typedef enum logic [1:0] {
        ADD_FIRST_DELAY = 2'd0,
        ADD_RESYNC      = 2'd1,
        ADD_ATTEMPT_TMO = 2'd2
    } t_add_sel;

    // Configuration register file contents.
    typedef struct packed {
        logic [TimeW-1:0] first_delay_ms;
        logic [TimeW-1:0] resync_period_ms;
        logic [TimeW-1:0] attempt_timeout_ms;
        logic [TimeW-1:0] fallback_test_ms;
    } t_cfg;

    // One input item.
    typedef struct packed {
        t_cmd             command;
        logic [TimeW-1:0] now_ms;
        logic             net_up;
        logic             time_valid;
        logic             static_config;
        t_sys_state       current_state;
    } t_item;

    // One result item.
    typedef struct packed {
        t_log_code    log_code;
        t_state_write state_write;
        logic         restore_addresses;
        logic         begin_fallback;
        logic         sync_success;
        logic         start_attempt;
    } t_result;

endpackage

@@ rtl/tsrs_cfg_regs.sv @@
// Configuration register file of the time sync retry supervisor.
// Depends on tsrs_pkg for the register indexes and reset values.
module tsrs_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tsrs_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [tsrs_pkg::TimeW-1:0]    i_cfg_data,
    output tsrs_pkg::t_cfg                o_cfg
);

    tsrs_pkg::t_cfg r_cfg;

    // Write one register per transfer; reset loads the default timings.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_delay_ms     <= tsrs_pkg::FirstDelayRst;
            r_cfg.resync_period_ms   <= tsrs_pkg::ResyncRst;
            r_cfg.attempt_timeout_ms <= tsrs_pkg::AttemptTmoRst;
            r_cfg.fallback_test_ms   <= tsrs_pkg::FallbackTestRst;
        end else if (i_cfg_we) begin
            case (tsrs_pkg::t_cfg_idx'(i_cfg_idx))
                tsrs_pkg::CFG_FIRST_DELAY:  r_cfg.first_delay_ms     <= i_cfg_data;
                tsrs_pkg::CFG_RESYNC:       r_cfg.resync_period_ms   <= i_cfg_data;
                tsrs_pkg::CFG_ATTEMPT_TMO:  r_cfg.attempt_timeout_ms <= i_cfg_data;
                tsrs_pkg::CFG_FALLBACK_TST: r_cfg.fallback_test_ms   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/tsrs_engine.sv @@
// Supervisor state and the single-pass decision logic for one item.
// Depends on tsrs_pkg; the top level supplies the registered item.
module tsrs_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  tsrs_pkg::t_item   i_item,
    input  tsrs_pkg::t_cfg    i_cfg,
    output tsrs_pkg::t_result o_result
);

    logic                      r_is_synced, n_is_synced;
    logic                      r_attempt_running, n_attempt_running;
    logic                      r_fallback_running, n_fallback_running;
    logic                      r_link_was_up, n_link_was_up;
    logic [tsrs_pkg::TimeW-1:0] r_next_due_ms, n_next_due_ms;
    logic [tsrs_pkg::TimeW-1:0] r_attempt_start_ms, n_attempt_start_ms;
    logic [tsrs_pkg::TimeW-1:0] r_fallback_start_ms, n_fallback_start_ms;

    logic [tsrs_pkg::TimeW-1:0] due_base;
    logic [tsrs_pkg::TimeW-1:0] due_diff;
    logic [tsrs_pkg::TimeW-1:0] att_elapsed;
    logic [tsrs_pkg::TimeW-1:0] fb_elapsed;
    logic [tsrs_pkg::TimeW-1:0] add_operand;
    logic [tsrs_pkg::TimeW-1:0] add_sum;
    logic                       att_timeout;
    logic                       fb_timeout;
    logic                       use_sum;
    tsrs_pkg::t_add_sel         add_sel;
    tsrs_pkg::t_result          result;

    // Wrapping differences and the link-up edge.
    assign due_base    = (i_item.net_up && !r_link_was_up) ? i_item.now_ms : r_next_due_ms;
    assign due_diff    = i_item.now_ms - due_base;
    assign att_elapsed = i_item.now_ms - r_attempt_start_ms;
    assign fb_elapsed  = i_item.now_ms - r_fallback_start_ms;
    assign att_timeout = att_elapsed > i_cfg.attempt_timeout_ms;
    assign fb_timeout  = fb_elapsed > i_cfg.fallback_test_ms;

    // Decision tree for one item.
    always_comb begin
        n_is_synced         = r_is_synced;
        n_attempt_running   = r_attempt_running;
        n_fallback_running  = r_fallback_running;
        n_link_was_up       = r_link_was_up;
        n_attempt_start_ms  = r_attempt_start_ms;
        n_fallback_start_ms = r_fallback_start_ms;
        add_sel             = tsrs_pkg::ADD_RESYNC;
        use_sum             = 1'b0;
        result              = '0;

        if (i_item.command == tsrs_pkg::CMD_START) begin
            // A start event only schedules the first attempt.
            add_sel = tsrs_pkg::ADD_FIRST_DELAY;
            use_sum = 1'b1;
        end else begin
            n_link_was_up = i_item.net_up;
            if (!i_item.net_up) begin
                // Link down: nothing beyond tracking the link.
            end else if ((!r_is_synced || r_fallback_running) && i_item.time_valid) begin
                // Success, either first sync or during the fallback test.
                n_is_synced        = 1'b1;
                n_attempt_running  = 1'b0;
                n_fallback_running = 1'b0;
                add_sel            = tsrs_pkg::ADD_RESYNC;
                use_sum            = 1'b1;
                result.sync_success = 1'b1;
                if (i_item.current_state == tsrs_pkg::SYS_FALLBACK ||
                    i_item.current_state == tsrs_pkg::SYS_ERROR) begin
                    result.state_write = tsrs_pkg::SW_RUN;
                end
            end else if (r_fallback_running) begin
                // The fallback test gave up: restore and wait a full interval.
                if (fb_timeout) begin
                    n_fallback_running       = 1'b0;
                    n_attempt_running        = 1'b0;
                    add_sel                  = tsrs_pkg::ADD_RESYNC;
                    use_sum                  = 1'b1;
                    result.restore_addresses = 1'b1;
                    result.state_write       = tsrs_pkg::SW_ERROR;
                    result.log_code          = tsrs_pkg::LOG_GAVE_UP;
                end
            end else if (r_attempt_running) begin
                // Attempt timeout: test the fallback addresses or retry later.
                if (att_timeout) begin
                    if (i_item.static_config) begin
                        n_fallback_running    = 1'b1;
                        n_fallback_start_ms   = i_item.now_ms;
                        result.begin_fallback = 1'b1;
                        result.state_write    = tsrs_pkg::SW_FALLBACK;
                        result.log_code       = tsrs_pkg::LOG_TEST_START;
                    end else begin
                        n_attempt_running = 1'b0;
                        add_sel           = tsrs_pkg::ADD_ATTEMPT_TMO;
                        use_sum           = 1'b1;
                        result.log_code   = tsrs_pkg::LOG_RETRY_LATER;
                    end
                end
            end else if (!due_diff[tsrs_pkg::TimeW-1]) begin
                // Due: launch an attempt.
                n_attempt_running    = 1'b1;
                n_attempt_start_ms   = i_item.now_ms;
                result.start_attempt = 1'b1;
            end
        end
    end

    // One shared adder for every rescheduling.
    always_comb begin
        case (add_sel)
            tsrs_pkg::ADD_FIRST_DELAY: add_operand = i_cfg.first_delay_ms;
            tsrs_pkg::ADD_RESYNC:      add_operand = i_cfg.resync_period_ms;
            tsrs_pkg::ADD_ATTEMPT_TMO: add_operand = i_cfg.attempt_timeout_ms;
            default:                   add_operand = i_cfg.resync_period_ms;
        endcase
    end

    assign add_sum = i_item.now_ms + add_operand;

    // A start event always overwrites the stored due time with the sum.
    always_comb begin
        if (use_sum) begin
            n_next_due_ms = add_sum;
        end else if (i_item.command == tsrs_pkg::CMD_START) begin
            n_next_due_ms = r_next_due_ms;
        end else begin
            n_next_due_ms = due_base;
        end
    end

    // State update once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_synced         <= 1'b0;
            r_attempt_running   <= 1'b0;
            r_fallback_running  <= 1'b0;
            r_link_was_up       <= 1'b0;
            r_next_due_ms       <= '0;
            r_attempt_start_ms  <= '0;
            r_fallback_start_ms <= '0;
        end else if (i_advance) begin
            r_is_synced         <= n_is_synced;
            r_attempt_running   <= n_attempt_running;
            r_fallback_running  <= n_fallback_running;
            r_link_was_up       <= n_link_was_up;
            r_next_due_ms       <= n_next_due_ms;
            r_attempt_start_ms  <= n_attempt_start_ms;
            r_fallback_start_ms <= n_fallback_start_ms;
        end
    end

    assign o_result = result;

endmodule

@@ rtl/time_sync_retry_supervisor_core.sv @@
// Top level of the time sync retry supervisor: stream ports, input and result registers.
// Depends on tsrs_pkg, tsrs_cfg_regs and tsrs_engine.
//
//  Channel   Direction  Handshake                      Payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready tdata 40 bits, tuser = command
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata 8 bits
//  cfg       in         i_cfg_we                        i_cfg_idx, i_cfg_data
//
// The result register loads from the input register when m_axis can take a
// result: one input register, then the decision logic and the state update
// feed the result register.
// One item per cycle is sustained while m_axis does not stall; the supervisor state
// is read and written in the same cycle, so consecutive items see each other's updates.
// A stall on m_axis holds the result; an empty input register still takes one more item.
// Reset (synchronous, active low) empties both registers, clears state, presets timings.
module time_sync_retry_supervisor_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // From bit 0: now_ms[31:0], net_up, time_valid, static_config,
    // current_state[1:0], zero fill[2:0].
    input  logic [tsrs_pkg::InDataW-1:0]  i_s_axis_tdata,
    // Bit 0: command.
    input  logic                          i_s_axis_tuser,
    // Result stream.
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // From bit 0: start_attempt, sync_success, begin_fallback, restore_addresses,
    // state_write[1:0], log_code[1:0].
    output logic [tsrs_pkg::OutDataW-1:0] o_m_axis_tdata,
    // Configuration writes.
    input  logic                          i_cfg_we,
    input  logic [tsrs_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [tsrs_pkg::TimeW-1:0]    i_cfg_data
);

    logic              r_in_valid;
    tsrs_pkg::t_item   r_item;
    logic              r_out_valid;
    tsrs_pkg::t_result r_result;
    tsrs_pkg::t_result result;
    tsrs_pkg::t_cfg    cfg;
    logic              advance;
    logic              in_xfer;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.command       <= tsrs_pkg::t_cmd'(i_s_axis_tuser);
            r_item.now_ms        <= i_s_axis_tdata[31:0];
            r_item.net_up        <= i_s_axis_tdata[32];
            r_item.time_valid    <= i_s_axis_tdata[33];
            r_item.static_config <= i_s_axis_tdata[34];
            r_item.current_state <= tsrs_pkg::t_sys_state'(i_s_axis_tdata[36:35]);
        end
    end

    tsrs_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tsrs_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_result;

endmodule

@@ rtl/tsrs_checker.sv @@
// Port-level checks for the time sync retry supervisor, bound to the top level.
// Depends on tsrs_pkg for widths and codes.
module tsrs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [tsrs_pkg::OutDataW-1:0] o_m_axis_tdata
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // No result appears right after reset without an item behind it.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // At most one action pulse per result.
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> $onehot0(o_m_axis_tdata[3:0]))
        else $error("more than one action pulse");

    // Starting the fallback test always requests the test state and logs it.
    a_fallback_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[2]) |->
        (o_m_axis_tdata[5:4] == tsrs_pkg::SW_FALLBACK &&
         o_m_axis_tdata[7:6] == tsrs_pkg::LOG_TEST_START))
        else $error("fallback start without matching codes");

    // A restore always requests error mode and logs the give-up.
    a_restore_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[3]) |->
        (o_m_axis_tdata[5:4] == tsrs_pkg::SW_ERROR &&
         o_m_axis_tdata[7:6] == tsrs_pkg::LOG_GAVE_UP))
        else $error("restore without matching codes");

endmodule

bind time_sync_retry_supervisor_core tsrs_checker u_tsrs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

@@ tb/tsrs_result_checker.sv @@
// Result checker for the time sync retry supervisor: mirrors the supervisor state
// from accepted input transfers and compares each result transfer with its prediction.
// Depends on tsrs_pkg for widths, codes and register reset values.
module tsrs_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream as seen on the block's ports.
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    // From bit 0: now_ms[31:0], net_up, time_valid, static_config,
    // current_state[1:0], zero fill[2:0].
    input  logic [tsrs_pkg::InDataW-1:0]  i_in_data,
    // Bit 0: command.
    input  logic                          i_in_user,
    // Result stream as seen on the block's ports.
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    // From bit 0: start_attempt, sync_success, begin_fallback, restore_addresses,
    // state_write[1:0], log_code[1:0].
    input  logic [tsrs_pkg::OutDataW-1:0] i_out_data,
    // Register writes.
    input  logic                          i_cfg_we,
    input  logic [tsrs_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [tsrs_pkg::TimeW-1:0]    i_cfg_data,
    output int                            o_mismatches,
    output int                            o_pending,
    output int                            o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Mirrored registers and supervisor state.
    tsrs_pkg::t_cfg             regs;
    logic                       synced;
    logic                       attempt_active;
    logic                       test_active;
    logic                       link_seen_up;
    logic [tsrs_pkg::TimeW-1:0] due_ms;
    logic [tsrs_pkg::TimeW-1:0] attempt_t0_ms;
    logic [tsrs_pkg::TimeW-1:0] test_t0_ms;

    // Results predicted for accepted items, oldest first.
    tsrs_pkg::t_result          predicted_results[$];
    tsrs_pkg::t_result          got_result;
    tsrs_pkg::t_result          want_result;

    // Works out the result of one item and advances the mirrored state.
    function automatic tsrs_pkg::t_result supervise_item(
        input tsrs_pkg::t_cmd cmd, input logic [tsrs_pkg::TimeW-1:0] now,
        input logic up, input logic tv, input logic stat, input logic [1:0] sys);
        tsrs_pkg::t_result          r;
        logic [tsrs_pkg::TimeW-1:0] elapsed;
        r = '0;

        // A start event only schedules the first attempt.
        if (cmd == tsrs_pkg::CMD_START) begin
            due_ms = now + regs.first_delay_ms;
            return r;
        end

        // A link that comes up pulls the next attempt to the present.
        if (up && !link_seen_up)
            due_ms = now;
        link_seen_up = up;
        if (!up)
            return r;

        // Success is taken before the first sync, or at any time during the test.
        if (tv && (!synced || test_active)) begin
            synced         = 1'b1;
            attempt_active = 1'b0;
            test_active    = 1'b0;
            due_ms         = now + regs.resync_period_ms;
            r.sync_success = 1'b1;
            if (sys == tsrs_pkg::SYS_FALLBACK || sys == tsrs_pkg::SYS_ERROR)
                r.state_write = tsrs_pkg::SW_RUN;
            return r;
        end

        // The fallback test gives up once its time has run out.
        if (test_active) begin
            elapsed = now - test_t0_ms;
            if (elapsed > regs.fallback_test_ms) begin
                r.restore_addresses = 1'b1;
                r.state_write       = tsrs_pkg::SW_ERROR;
                r.log_code          = tsrs_pkg::LOG_GAVE_UP;
                test_active         = 1'b0;
                attempt_active      = 1'b0;
                due_ms              = now + regs.resync_period_ms;
            end
            return r;
        end

        // A timed-out attempt starts the test with static addresses, else retries later.
        if (attempt_active) begin
            elapsed = now - attempt_t0_ms;
            if (elapsed > regs.attempt_timeout_ms) begin
                if (stat) begin
                    r.begin_fallback = 1'b1;
                    r.state_write    = tsrs_pkg::SW_FALLBACK;
                    r.log_code       = tsrs_pkg::LOG_TEST_START;
                    test_active      = 1'b1;
                    test_t0_ms       = now;
                end else begin
                    r.log_code     = tsrs_pkg::LOG_RETRY_LATER;
                    attempt_active = 1'b0;
                    due_ms         = now + regs.attempt_timeout_ms;
                end
            end
            return r;
        end

        // An attempt is due when the wrapped distance to the due time is not negative.
        elapsed = now - due_ms;
        if (!elapsed[tsrs_pkg::TimeW-1]) begin
            r.start_attempt = 1'b1;
            attempt_active  = 1'b1;
            attempt_t0_ms   = now;
        end
        return r;
    endfunction

    // Register writes, result comparison and prediction, in that order per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.first_delay_ms     = tsrs_pkg::FirstDelayRst;
            regs.resync_period_ms   = tsrs_pkg::ResyncRst;
            regs.attempt_timeout_ms = tsrs_pkg::AttemptTmoRst;
            regs.fallback_test_ms   = tsrs_pkg::FallbackTestRst;
            synced         = 1'b0;
            attempt_active = 1'b0;
            test_active    = 1'b0;
            link_seen_up   = 1'b0;
            due_ms         = '0;
            attempt_t0_ms  = '0;
            test_t0_ms     = '0;
            predicted_results.delete();
            o_mismatches   = 0;
            o_checked      = 0;
        end else begin
            if (i_cfg_we) begin
                case (tsrs_pkg::t_cfg_idx'(i_cfg_idx))
                    tsrs_pkg::CFG_FIRST_DELAY:  regs.first_delay_ms     = i_cfg_data;
                    tsrs_pkg::CFG_RESYNC:       regs.resync_period_ms   = i_cfg_data;
                    tsrs_pkg::CFG_ATTEMPT_TMO:  regs.attempt_timeout_ms = i_cfg_data;
                    tsrs_pkg::CFG_FALLBACK_TST: regs.fallback_test_ms   = i_cfg_data;
                    default: ;
                endcase
            end

            // Result transfer: compare against the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                got_result = tsrs_pkg::t_result'(i_out_data);
                if (predicted_results.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: result transfer with nothing predicted, actual data %02h",
                             $time, i_out_data);
                end else begin
                    want_result = predicted_results.pop_front();
                    o_checked++;
                    if (got_result !== want_result) begin
                        o_mismatches++;
                        $display({"%0t: result mismatch, expected start=%0b success=%0b ",
                                  "fallback=%0b restore=%0b state_write=%0d log=%0d, actual ",
                                  "start=%0b success=%0b fallback=%0b restore=%0b ",
                                  "state_write=%0d log=%0d"}, $time,
                                 want_result.start_attempt, want_result.sync_success,
                                 want_result.begin_fallback, want_result.restore_addresses,
                                 want_result.state_write, want_result.log_code,
                                 got_result.start_attempt, got_result.sync_success,
                                 got_result.begin_fallback, got_result.restore_addresses,
                                 got_result.state_write, got_result.log_code);
                    end
                end
            end

            // Input transfer: predict its result.
            if (i_in_valid && i_in_ready) begin
                predicted_results.push_back(supervise_item(
                    tsrs_pkg::t_cmd'(i_in_user),
                    i_in_data[tsrs_pkg::TimeW-1:0],
                    i_in_data[tsrs_pkg::TimeW],
                    i_in_data[tsrs_pkg::TimeW+1],
                    i_in_data[tsrs_pkg::TimeW+2],
                    i_in_data[tsrs_pkg::TimeW+4:tsrs_pkg::TimeW+3]));
            end
        end
        o_pending = predicted_results.size();
    end

endmodule

@@ tb/time_sync_retry_supervisor_core_tb.sv @@
// Testbench top for time_sync_retry_supervisor_core: clock, reset, register settings,
// item stimulus with random pacing, a watchdog and the verdict.
// Depends on tsrs_pkg, the block itself and tsrs_result_checker.
module time_sync_retry_supervisor_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         QuietLimit   = 2000;
    localparam int         LongHold     = 60;
    localparam int         SettleCycles = 4;
    localparam logic [1:0] SysUnused    = 2'd3;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          s_valid    = 1'b0;
    logic [tsrs_pkg::InDataW-1:0]  s_data     = '0;
    logic                          s_user     = 1'b0;
    logic                          m_ready    = 1'b0;
    logic                          cfg_we     = 1'b0;
    logic [tsrs_pkg::CfgIdxW-1:0]  cfg_idx    = '0;
    logic [tsrs_pkg::TimeW-1:0]    cfg_data   = '0;
    logic                          o_s_axis_tready;
    logic                          o_m_axis_tvalid;
    logic [tsrs_pkg::OutDataW-1:0] o_m_axis_tdata;

    int                            mismatches;
    int                            pending;
    int                            checked;
    int                            items_sent    = 0;
    int unsigned                   send_idle_pct = 0;
    int unsigned                   stall_pct     = 0;
    logic                          hold_wanted   = 1'b0;
    logic [tsrs_pkg::TimeW-1:0]    wall_ms       = 32'hFFFF_FFF0;

    time_sync_retry_supervisor_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    tsrs_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_valid),
        .i_in_ready   (o_s_axis_tready),
        .i_in_data    (s_data),
        .i_in_user    (s_user),
        .i_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (m_ready),
        .i_out_data   (o_m_axis_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 100 MHz clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stalls, plus one long hold-off while the sender keeps going.
    initial begin : result_sink
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_wanted && !hold_done) begin
                hold_left = LongHold;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge i_clk);
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("CHECKS FAILED");
        $finish;
    end

    // One register write; the enable stays high across back-to-back writes.
    task automatic write_reg(input tsrs_pkg::t_cfg_idx idx,
                             input logic [tsrs_pkg::TimeW-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [tsrs_pkg::TimeW-1:0] first,
                                input logic [tsrs_pkg::TimeW-1:0] resync,
                                input logic [tsrs_pkg::TimeW-1:0] tmo,
                                input logic [tsrs_pkg::TimeW-1:0] test);
        write_reg(tsrs_pkg::CFG_FIRST_DELAY, first);
        write_reg(tsrs_pkg::CFG_RESYNC, resync);
        write_reg(tsrs_pkg::CFG_ATTEMPT_TMO, tmo);
        write_reg(tsrs_pkg::CFG_FALLBACK_TST, test);
        cfg_we <= 1'b0;
    endtask

    // Offers one item, with random sender gaps, and returns after its transfer.
    task automatic send_item(input tsrs_pkg::t_cmd cmd, input logic [tsrs_pkg::TimeW-1:0] now,
                             input logic up, input logic tv, input logic stat,
                             input logic [1:0] sys);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {3'b000, sys, stat, tv, up, now};
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic poll(input logic [tsrs_pkg::TimeW-1:0] step, input logic up,
                        input logic tv, input logic stat, input logic [1:0] sys);
        wall_ms += step;
        send_item(tsrs_pkg::CMD_POLL, wall_ms, up, tv, stat, sys);
    endtask

    task automatic start_event(input logic [tsrs_pkg::TimeW-1:0] step, input logic up,
                               input logic tv, input logic stat, input logic [1:0] sys);
        wall_ms += step;
        send_item(tsrs_pkg::CMD_START, wall_ms, up, tv, stat, sys);
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // Mostly well-formed polls on a moving clock, with start events and noise mixed in.
    task automatic random_phase(input int count, input logic [tsrs_pkg::TimeW-1:0] step_max);
        int unsigned roll;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                start_event($urandom_range(0, step_max), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            2'($urandom_range(0, 3)));
            end else if (roll < 12) begin
                send_item(tsrs_pkg::CMD_POLL, $urandom, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          2'($urandom_range(0, 3)));
            end else begin
                poll($urandom_range(0, step_max), $urandom_range(0, 99) < 94,
                     $urandom_range(0, 99) < 6, 1'($urandom_range(0, 1)),
                     2'($urandom_range(0, 3)));
            end
        end
    endtask

    // Main sequence.
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Short timings so that every path is reached within a few polls.
        program_regs(32'd10, 32'd1000, 32'd20, 32'd30);

        // Directed walk across the clock wrap: schedule, retry, test, give up, sync.
        start_event(0, 1'b0, 1'b1, 1'b1, SysUnused);
        poll(15, 1'b1, 1'b0, 1'b0, tsrs_pkg::SYS_OTHER);    // link comes up at the top
        poll(1, 1'b1, 1'b0, 1'b0, tsrs_pkg::SYS_OTHER);     // counter at zero, still in time
        poll(20, 1'b1, 1'b0, 1'b0, tsrs_pkg::SYS_OTHER);    // timeout without static addresses
        poll(10, 1'b1, 1'b0, 1'b0, tsrs_pkg::SYS_OTHER);    // retry not yet due
        poll(10, 1'b1, 1'b0, 1'b0, tsrs_pkg::SYS_OTHER);    // retry due exactly now
        poll(21, 1'b1, 1'b0, 1'b1, tsrs_pkg::SYS_OTHER);    // timeout with static addresses
        poll(30, 1'b1, 1'b0, 1'b1, tsrs_pkg::SYS_FALLBACK); // test at its exact limit
        poll(1, 1'b1, 1'b0, 1'b1, tsrs_pkg::SYS_FALLBACK);  // test gives up
        poll(5, 1'b0, 1'b1, 1'b1, tsrs_pkg::SYS_ERROR);     // link down hides everything
        poll(5, 1'b1, 1'b0, 1'b0, tsrs_pkg::SYS_ERROR);     // link edge pulls the attempt in
        poll(3, 1'b1, 1'b1, 1'b0, tsrs_pkg::SYS_ERROR);     // first sync
        start_event(4, 1'b0, 1'b1, 1'b1, tsrs_pkg::SYS_FALLBACK);
        poll(10, 1'b1, 1'b0, 1'b1, tsrs_pkg::SYS_OTHER);
        poll(21, 1'b1, 1'b0, 1'b1, tsrs_pkg::SYS_OTHER);
        poll(2, 1'b1, 1'b1, 1'b1, tsrs_pkg::SYS_FALLBACK);  // success while the test runs
        poll(2, 1'b1, 1'b1, 1'b0, tsrs_pkg::SYS_OTHER);     // already synced, nothing due
        poll(1000, 1'b1, 1'b0, 1'b0, SysUnused);
        poll(21, 1'b1, 1'b0, 1'b0, SysUnused);
        poll(20, 1'b1, 1'b1, 1'b0, tsrs_pkg::SYS_OTHER);
        poll(40, 1'b1, 1'b0, 1'b1, tsrs_pkg::SYS_OTHER);
        poll(31, 1'b1, 1'b0, 1'b1, tsrs_pkg::SYS_ERROR);
        settle();

        // No idling, small random timings, one long result hold-off.
        program_regs($urandom_range(0, 50), $urandom_range(100, 400),
                     $urandom_range(0, 40), $urandom_range(0, 40));
        hold_wanted = 1'b1;
        random_phase(440, 32'd30);
        settle();

        // Sender gaps, every register at its maximum.
        send_idle_pct = 45;
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(200, 32'hFFFF_FFFF);
        settle();

        // Receiver stalls, every register at zero.
        send_idle_pct = 0;
        stall_pct     = 45;
        program_regs(32'd0, 32'd0, 32'd0, 32'd0);
        random_phase(440, 32'd3);
        settle();

        // Both sides idle, reset timings on a coarse clock.
        send_idle_pct = 34;
        stall_pct     = 34;
        program_regs(tsrs_pkg::FirstDelayRst, tsrs_pkg::ResyncRst,
                     tsrs_pkg::AttemptTmoRst, tsrs_pkg::FallbackTestRst);
        random_phase(440, 32'd200000);
        settle();

        $display("Sent %0d items (directed walk, start events, polls, noise) under five",
                 items_sent);
        $display("register settings; %0d results compared across four pacing phases.",
                 checked);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
